>>> design/snrf_pkg.sv
// ----------------------------------------------------------------------------
// snrf_pkg
// shared constants, types and helpers of the sliding negative rank filter
// ----------------------------------------------------------------------------
package snrf_pkg;

	localparam int WINDOW_MAX = 256;
	localparam int WIN_AW     = $clog2(WINDOW_MAX);
	localparam int WLEN_W     = WIN_AW + 1;
	localparam int MAX_MAG    = 50;
	localparam int HIST_BINS  = MAX_MAG + 1;
	localparam int HIST_AW    = $clog2(HIST_BINS);
	localparam int BIN_W      = 9;
	localparam int CNT_W      = BIN_W + 1;
	localparam int SMP_W      = 7;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANK       = 8'd1;

	localparam logic signed [SMP_W-1:0] SMP_MIN = -7'sd50;

	typedef struct packed {
		logic               rd_en;
		logic [HIST_AW-1:0] rd_addr;
		logic               wr_en;
		logic [HIST_AW-1:0] wr_addr;
		logic [BIN_W-1:0]   wr_data;
		logic               clear;
	} hist_req_t;

	// magnitude of a negative sample
	function automatic logic [HIST_AW-1:0] neg_mag(input logic [SMP_W-1:0] x);
		logic [SMP_W-1:0] t;
		t = ~x + 7'd1;
		return t[HIST_AW-1:0];
	endfunction

endpackage

>>> design/snrf_ram.sv
// ----------------------------------------------------------------------------
// snrf_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module snrf_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/snrf_hist.sv
// ----------------------------------------------------------------------------
// snrf_hist
// magnitude histogram: bin ram plus per-bin valid flags, unwritten bins read 0
// ----------------------------------------------------------------------------
module snrf_hist (
	input  logic                       clk,
	input  logic                       arst_n,
	input  snrf_pkg::hist_req_t        req,
	output logic [snrf_pkg::BIN_W-1:0] rdata
);

	logic [snrf_pkg::HIST_BINS-1:0] valid_q;
	logic                           rd_valid_q;
	logic [snrf_pkg::BIN_W-1:0]     ram_rdata;

	snrf_ram #(
		.W(snrf_pkg::BIN_W),
		.D(snrf_pkg::HIST_BINS)
	) u_ram (
		.clk  (clk),
		.we   (req.wr_en),
		.waddr(req.wr_addr),
		.wdata(req.wr_data),
		.re   (req.rd_en),
		.raddr(req.rd_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.clear) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rdata = rd_valid_q ? ram_rdata : '0;

endmodule

>>> design/snrf_seq.sv
// ----------------------------------------------------------------------------
// snrf_seq
// sequencer: ring update, histogram update and rank scan over one shared adder
// ----------------------------------------------------------------------------
module snrf_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [snrf_pkg::SMP_W-1:0]      smp,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [snrf_pkg::SMP_W-1:0]      res,
	input  logic                            cfg_valid,
	input  logic [snrf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [snrf_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                            win_re,
	output logic                            win_we,
	output logic [snrf_pkg::WIN_AW-1:0]     win_addr,
	output logic [snrf_pkg::SMP_W-1:0]      win_wdata,
	input  logic [snrf_pkg::SMP_W-1:0]      win_rdata,
	output snrf_pkg::hist_req_t             hist_req,
	input  logic [snrf_pkg::BIN_W-1:0]      hist_rdata
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_OLD   = 8'b0000_0010,
		ST_DEC   = 8'b0000_0100,
		ST_INCRD = 8'b0000_1000,
		ST_INC   = 8'b0001_0000,
		ST_UPD   = 8'b0010_0000,
		ST_SCAN  = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	state_t                            state_q;
	logic [snrf_pkg::WLEN_W-1:0]       wl_q;
	logic [snrf_pkg::CFG_DATA_W-1:0]   rank_q;
	logic [snrf_pkg::WIN_AW-1:0]       wp_q;
	logic [snrf_pkg::WLEN_W-1:0]       fill_q;
	logic [snrf_pkg::SMP_W-1:0]        smp_q;
	logic                              full_q;
	logic [snrf_pkg::HIST_AW-1:0]      old_mag_q;
	logic [snrf_pkg::CNT_W-1:0]        cnt_q;
	logic [snrf_pkg::HIST_AW-1:0]      bin_q;
	logic [snrf_pkg::SMP_W-1:0]        res_q;
	logic                              out_valid_q;
	logic [snrf_pkg::SMP_W-1:0]        out_data_q;

	logic [snrf_pkg::WLEN_W-1:0]       weff;
	logic [snrf_pkg::CFG_DATA_W-1:0]   need;
	logic [snrf_pkg::SMP_W-1:0]        smp_sat;
	logic [snrf_pkg::CNT_W-1:0]        alu_a;
	logic [snrf_pkg::CNT_W-1:0]        alu_b;
	logic [snrf_pkg::CNT_W-1:0]        alu_sum;
	logic [snrf_pkg::WLEN_W-1:0]       wp_inc;
	logic [snrf_pkg::WLEN_W-1:0]       fill_nxt;
	logic                              in_xfer;
	logic                              cfg_wlen;

	always_comb begin
		if (wl_q == '0) begin
			weff = snrf_pkg::WLEN_W'(1);
		end else if (wl_q > snrf_pkg::WLEN_W'(snrf_pkg::WINDOW_MAX)) begin
			weff = snrf_pkg::WLEN_W'(snrf_pkg::WINDOW_MAX);
		end else begin
			weff = wl_q;
		end
	end

	assign need     = (rank_q == '0) ? snrf_pkg::CFG_DATA_W'(1) : rank_q;
	assign smp_sat  = ($signed(smp) < snrf_pkg::SMP_MIN) ? snrf_pkg::SMP_MIN : smp;
	assign wp_inc   = {1'b0, wp_q} + snrf_pkg::WLEN_W'(1);
	assign fill_nxt = (fill_q < weff) ? fill_q + snrf_pkg::WLEN_W'(1) : fill_q;
	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign cfg_wlen = cfg_valid && (cfg_index == snrf_pkg::CFG_WINDOW_LEN);

	// shared adder: bin decrement, bin increment and scan accumulation
	always_comb begin
		alu_a = {1'b0, hist_rdata};
		alu_b = snrf_pkg::CNT_W'(1);
		case (state_q)
			ST_DEC:  alu_b = '1;
			ST_SCAN: begin
				alu_a = cnt_q;
				alu_b = {1'b0, hist_rdata};
			end
			default: alu_b = snrf_pkg::CNT_W'(1);
		endcase
	end
	assign alu_sum = alu_a + alu_b;

	always_comb begin
		win_re           = in_xfer;
		win_we           = (state_q == ST_OLD);
		win_addr         = wp_q;
		win_wdata        = smp_q;
		hist_req         = '0;
		hist_req.clear   = cfg_wlen;
		case (state_q)
			ST_OLD: begin
				hist_req.rd_en   = full_q && win_rdata[snrf_pkg::SMP_W-1];
				hist_req.rd_addr = snrf_pkg::neg_mag(win_rdata);
			end
			ST_DEC: begin
				hist_req.wr_en   = (hist_rdata != '0);
				hist_req.wr_addr = old_mag_q;
				hist_req.wr_data = alu_sum[snrf_pkg::BIN_W-1:0];
			end
			ST_INCRD: begin
				hist_req.rd_en   = smp_q[snrf_pkg::SMP_W-1];
				hist_req.rd_addr = snrf_pkg::neg_mag(smp_q);
			end
			ST_INC: begin
				hist_req.wr_en   = 1'b1;
				hist_req.wr_addr = snrf_pkg::neg_mag(smp_q);
				hist_req.wr_data = alu_sum[snrf_pkg::BIN_W-1:0];
			end
			ST_UPD: begin
				hist_req.rd_en   = (fill_nxt >= weff);
				hist_req.rd_addr = snrf_pkg::HIST_AW'(snrf_pkg::MAX_MAG);
			end
			ST_SCAN: begin
				hist_req.rd_en   = 1'b1;
				hist_req.rd_addr = bin_q - snrf_pkg::HIST_AW'(1);
			end
			default: hist_req.rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wl_q        <= snrf_pkg::WLEN_W'(1);
			rank_q      <= snrf_pkg::CFG_DATA_W'(1);
			wp_q        <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wlen) begin
				wl_q   <= cfg_data;
				wp_q   <= '0;
				fill_q <= '0;
			end
			if (cfg_valid && (cfg_index == snrf_pkg::CFG_RANK)) begin
				rank_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_OLD;
					end
				end
				ST_OLD: begin
					if (full_q && win_rdata[snrf_pkg::SMP_W-1]) begin
						state_q <= ST_DEC;
					end else begin
						state_q <= ST_INCRD;
					end
				end
				ST_DEC:   state_q <= ST_INCRD;
				ST_INCRD: state_q <= smp_q[snrf_pkg::SMP_W-1] ? ST_INC : ST_UPD;
				ST_INC:   state_q <= ST_UPD;
				ST_UPD: begin
					wp_q   <= (wp_inc >= weff) ? '0 : wp_inc[snrf_pkg::WIN_AW-1:0];
					fill_q <= fill_nxt;
					if (fill_nxt >= weff) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (alu_sum >= {1'b0, need} || bin_q == snrf_pkg::HIST_AW'(1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				smp_q  <= smp_sat;
				full_q <= (fill_q >= weff);
			end
			ST_OLD: old_mag_q <= snrf_pkg::neg_mag(win_rdata);
			ST_UPD: begin
				cnt_q <= '0;
				bin_q <= snrf_pkg::HIST_AW'(snrf_pkg::MAX_MAG);
			end
			ST_SCAN: begin
				cnt_q <= alu_sum;
				bin_q <= bin_q - snrf_pkg::HIST_AW'(1);
				if (alu_sum >= {1'b0, need}) begin
					res_q <= ~{1'b0, bin_q} + snrf_pkg::SMP_W'(1);
				end else begin
					res_q <= '0;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_data_q <= res_q;
				end
			end
			default: cnt_q <= cnt_q;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign res           = out_data_q;

endmodule

>>> design/sliding_negative_rank_filter_top.sv
// ----------------------------------------------------------------------------
// sliding_negative_rank_filter_top
// rank-th smallest negative sample over a sliding window, via a magnitude
// histogram scanned one bin per cycle
// ----------------------------------------------------------------------------
// channel   direction  tdata / payload                     handshake
// s_axis    in         [6:0] sample, [7] zero             tvalid / tready
// m_axis    out        [6:0] beauty, [7] zero             tvalid / tready
// cfg       in         index 0 window_len, 1 rank         cfg_valid / cfg_ready
//
// an item passes the idle, old, optional decrement, increment read, optional
// increment and update states, and once results flow the rank scan reads one
// bin per cycle through the single read port of the bin ram, 50 bins at most
// reset clears the histogram flags, ring pointer and fill count at once
// a finished result waits in the output register while the next sample is
// taken; a new result stalls only while that register is still occupied
// ----------------------------------------------------------------------------
module sliding_negative_rank_filter_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,   // [6:0] sample
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [7:0]                      m_axis_tdata,   // [6:0] beauty
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [snrf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [snrf_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic                          win_re;
	logic                          win_we;
	logic [snrf_pkg::WIN_AW-1:0]   win_addr;
	logic [snrf_pkg::SMP_W-1:0]    win_wdata;
	logic [snrf_pkg::SMP_W-1:0]    win_rdata;
	snrf_pkg::hist_req_t           hist_req;
	logic [snrf_pkg::BIN_W-1:0]    hist_rdata;
	logic [snrf_pkg::SMP_W-1:0]    res;

	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = {1'b0, res};

	snrf_ram #(
		.W(snrf_pkg::SMP_W),
		.D(snrf_pkg::WINDOW_MAX)
	) u_win_ram (
		.clk  (clk),
		.we   (win_we),
		.waddr(win_addr),
		.wdata(win_wdata),
		.re   (win_re),
		.raddr(win_addr),
		.rdata(win_rdata)
	);

	snrf_hist u_hist (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (hist_req),
		.rdata (hist_rdata)
	);

	snrf_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.smp          (s_axis_tdata[snrf_pkg::SMP_W-1:0]),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.res          (res),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.win_re       (win_re),
		.win_we       (win_we),
		.win_addr     (win_addr),
		.win_wdata    (win_wdata),
		.win_rdata    (win_rdata),
		.hist_req     (hist_req),
		.hist_rdata   (hist_rdata)
	);

endmodule

>>> design/snrf_checker.sv
// ----------------------------------------------------------------------------
// snrf_checker
// port-level checks of the sliding negative rank filter, bound to the top
// ----------------------------------------------------------------------------
module snrf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata
);

	// not ready in the cycle after each input transfer
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken on consecutive cycles");

	// a result never appears right after an input transfer
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
		else $error("result too early");

	// result is zero or a negative value no smaller than -50
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata == 8'd0) ||
			(m_axis_tdata[7:6] == 2'b01 && m_axis_tdata[5:0] >= 6'd14))
		else $error("result out of range");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind sliding_negative_rank_filter_top snrf_checker u_snrf_checker (.*);

>>> sim/snrf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// snrf_tb_checker
// watches the sample, result and register channels of the sliding negative
// rank filter, keeps its own window and magnitude histogram, predicts each
// result and compares it with what the block delivers
// ----------------------------------------------------------------------------
module snrf_tb_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [7:0]                      m_axis_tdata,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [snrf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [snrf_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              errors,
	output int                              pending
);

	logic signed [snrf_pkg::SMP_W-1:0] ring [snrf_pkg::WINDOW_MAX];
	logic [snrf_pkg::BIN_W-1:0]        hist [snrf_pkg::HIST_BINS];
	int unsigned                       wr_ptr;
	int unsigned                       held;
	logic [snrf_pkg::CFG_DATA_W-1:0]   win_len_reg;
	logic [snrf_pkg::CFG_DATA_W-1:0]   rank_reg;
	logic signed [snrf_pkg::SMP_W-1:0] beauty_due [$];

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		errors++;
	endtask

	task automatic restart_window();
		for (int i = 0; i < snrf_pkg::HIST_BINS; i++)
			hist[i] = '0;
		wr_ptr = 0;
		held = 0;
	endtask

	function automatic logic signed [snrf_pkg::SMP_W-1:0] scan_rank();
		int unsigned need;
		int unsigned cnt;
		need = (rank_reg == 0) ? 1 : rank_reg;
		cnt = 0;
		for (int m = snrf_pkg::MAX_MAG; m >= 1; m--) begin
			cnt += hist[m];
			if (cnt >= need)
				return snrf_pkg::SMP_W'(-m);
		end
		return '0;
	endfunction

	task automatic admit_sample(input logic [snrf_pkg::SMP_W-1:0] raw);
		int unsigned w;
		int          s;
		int          old;
		w = (win_len_reg == 0) ? 1 :
			(win_len_reg > snrf_pkg::WINDOW_MAX) ? snrf_pkg::WINDOW_MAX : win_len_reg;
		s = int'($signed(raw));
		if (s < -snrf_pkg::MAX_MAG)
			s = -snrf_pkg::MAX_MAG;
		if (held >= w) begin
			old = int'(ring[wr_ptr]);
			if (old < 0 && hist[-old] > 0)
				hist[-old]--;
		end
		ring[wr_ptr] = snrf_pkg::SMP_W'(s);
		if (s < 0)
			hist[-s]++;
		wr_ptr = (wr_ptr + 1 >= w) ? 0 : wr_ptr + 1;
		if (held < w)
			held++;
		if (held >= w)
			beauty_due.insert(beauty_due.size(), scan_rank());
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_reg = 9'd1;
			rank_reg = 9'd1;
			restart_window();
			beauty_due.delete();
			errors = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (beauty_due.size() == 0) begin
					report_mismatch($sformatf("result %0d with none expected",
						$signed(m_axis_tdata[snrf_pkg::SMP_W-1:0])));
				end else begin
					if (m_axis_tdata[snrf_pkg::SMP_W-1:0] !== beauty_due[0])
						report_mismatch($sformatf("beauty %0d, expected %0d",
							$signed(m_axis_tdata[snrf_pkg::SMP_W-1:0]), beauty_due[0]));
					void'(beauty_due.pop_front());
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					snrf_pkg::CFG_WINDOW_LEN: begin
						win_len_reg = cfg_data;
						restart_window();
					end
					snrf_pkg::CFG_RANK: begin
						rank_reg = cfg_data;
					end
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				admit_sample(s_axis_tdata[snrf_pkg::SMP_W-1:0]);
		end
		pending = beauty_due.size();
	end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives samples and register writes into the sliding negative rank filter
// in random bursts against a stalling receiver; a checker beside the block
// predicts every result and counts mismatches
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [snrf_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 8'd5;
	localparam int                             SETTLE       = 80;

	logic                            clk;
	logic                            arst_n        = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [7:0]                      s_axis_tdata  = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [7:0]                      m_axis_tdata;
	logic                            cfg_valid     = 1'b0;
	logic                            cfg_ready;
	logic [snrf_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [snrf_pkg::CFG_DATA_W-1:0] cfg_data      = '0;
	int                              errors;
	int                              pending;

	int                              burst_left = 0;
	int                              rdy_run = 0;
	int                              stall_run = 0;

	sliding_negative_rank_filter_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	snrf_tb_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("TB_ERROR");
		$finish;
	end

	// receiver: ready runs, then an optional stall
	always @(negedge clk) begin
		if (rdy_run > 0) begin
			rdy_run--;
			m_axis_tready <= 1'b1;
		end else if (stall_run > 0) begin
			stall_run--;
			m_axis_tready <= 1'b0;
		end else begin
			rdy_run = $urandom_range(1, 40);
			stall_run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			m_axis_tready <= 1'b1;
		end
	end

	function automatic logic [snrf_pkg::SMP_W-1:0] next_sample(input int neg_pct);
		int v;
		if ($urandom_range(0, 7) == 0)
			return snrf_pkg::SMP_W'($urandom);
		if ($urandom_range(0, 99) < neg_pct)
			v = -int'($urandom_range(1, snrf_pkg::MAX_MAG));
		else
			v = $urandom_range(0, snrf_pkg::MAX_MAG);
		return snrf_pkg::SMP_W'(v);
	endfunction

	task automatic send_sample(input logic [snrf_pkg::SMP_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, v};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic end_stream();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
	endtask

	task automatic wait_idle();
		end_stream();
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [snrf_pkg::CFG_IDX_W-1:0] idx,
		input logic [snrf_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_samples(input int count, input int neg_pct);
		for (int i = 0; i < count; i++)
			send_sample(next_sample(neg_pct));
	endtask

	initial begin
		int wl;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: window of one, rank one, saturation below the range
		send_sample(7'(-50));
		send_sample(7'(0));
		send_sample(7'(63));
		send_sample(7'(-64));
		wait_idle();

		// window length zero behaves as one
		write_reg(snrf_pkg::CFG_WINDOW_LEN, 9'd0);
		send_sample(7'(-1));
		send_sample(7'(50));
		wait_idle();

		// short window filling up, rank zero behaves as one
		write_reg(snrf_pkg::CFG_WINDOW_LEN, 9'd4);
		write_reg(snrf_pkg::CFG_RANK, 9'd0);
		send_sample(7'(-64));
		send_sample(7'(-51));
		send_sample(7'(-1));
		send_sample(7'(1));
		send_sample(7'(51));
		send_sample(7'(-30));
		send_sample(7'(0));
		wait_idle();

		// rank change keeps the window, unmapped index is dropped
		write_reg(snrf_pkg::CFG_RANK, 9'd3);
		write_reg(CFG_UNMAPPED, 9'h1FF);
		send_sample(7'(-2));
		send_sample(7'(-3));
		send_sample(7'(-63));
		wait_idle();

		// rank above the count of negatives
		write_reg(snrf_pkg::CFG_RANK, 9'h1FF);
		send_sample(7'(-5));
		send_sample(7'(-6));
		wait_idle();

		// largest window
		write_reg(snrf_pkg::CFG_WINDOW_LEN, 9'd256);
		write_reg(snrf_pkg::CFG_RANK, 9'd1);
		run_samples(270, 60);
		wait_idle();

		// window above the maximum, rank at the maximum window
		write_reg(snrf_pkg::CFG_WINDOW_LEN, 9'h1FF);
		write_reg(snrf_pkg::CFG_RANK, 9'd256);
		run_samples(270, 97);
		wait_idle();

		for (int p = 0; p < 12; p++) begin
			wl = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
			write_reg(snrf_pkg::CFG_WINDOW_LEN, snrf_pkg::CFG_DATA_W'(wl));
			write_reg(snrf_pkg::CFG_RANK, snrf_pkg::CFG_DATA_W'($urandom_range(0, wl + 2)));
			run_samples(30, $urandom_range(20, 95));
			wait_idle();
			write_reg(snrf_pkg::CFG_RANK, snrf_pkg::CFG_DATA_W'($urandom_range(0, wl + 2)));
			run_samples(30, $urandom_range(20, 95));
			wait_idle();
		end

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
